>>> src/fcu_pkg.sv
package fcu_pkg;

	localparam int PITCH_LIMIT  = 22784;
	localparam int YAW_FULL     = 92160;
	localparam int YAW_HALF     = 46080;
	localparam int YAW_QUARTER  = 23040;
	localparam int CORDIC_STEPS = 16;
	localparam int CORDIC_GAIN  = 652032874;
	localparam int DIR_ONE      = 16384;

	typedef enum logic [2:0] {
		CFG_MOVE_SPEED = 3'd0,
		CFG_TURN_SPEED = 3'd1,
		CFG_UP_X       = 3'd2,
		CFG_UP_Y       = 3'd3,
		CFG_UP_Z       = 3'd4
	} cfg_index_t;

	typedef struct packed {
		logic fwd;
		logic bwd;
		logic left;
		logic right;
		logic pitch_up;
		logic pitch_down;
		logic yaw_left;
		logic yaw_right;
	} keys_t;

	typedef struct packed {
		logic [15:0]        move_speed;
		logic [15:0]        turn_speed;
		logic signed [15:0] up_x;
		logic signed [15:0] up_y;
		logic signed [15:0] up_z;
	} cfg_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] dir_z;
		logic signed [15:0] pitch_deg;
		logic [16:0]        yaw_deg;
	} result_t;

	function automatic logic signed [25:0] atan_q16deg(input logic [3:0] idx);
		logic signed [25:0] a;
		case (idx)
			4'd0:    a = 26'sd2949120;
			4'd1:    a = 26'sd1740967;
			4'd2:    a = 26'sd919879;
			4'd3:    a = 26'sd466945;
			4'd4:    a = 26'sd234379;
			4'd5:    a = 26'sd117305;
			4'd6:    a = 26'sd58666;
			4'd7:    a = 26'sd29335;
			4'd8:    a = 26'sd14668;
			4'd9:    a = 26'sd7334;
			4'd10:   a = 26'sd3667;
			4'd11:   a = 26'sd1833;
			4'd12:   a = 26'sd917;
			4'd13:   a = 26'sd458;
			4'd14:   a = 26'sd229;
			4'd15:   a = 26'sd115;
			default: a = 26'sd0;
		endcase
		return a;
	endfunction

endpackage

>>> src/fcu_ifs.sv
interface fcu_cmd_if;
	logic        valid;
	logic        ready;
	logic        key_forward;
	logic        key_backward;
	logic        key_left;
	logic        key_right;
	logic        key_pitch_up;
	logic        key_pitch_down;
	logic        key_yaw_left;
	logic        key_yaw_right;
	logic [15:0] frame_time;

	modport source(output valid, key_forward, key_backward, key_left, key_right,
		key_pitch_up, key_pitch_down, key_yaw_left, key_yaw_right, frame_time,
		input ready);
	modport sink(input valid, key_forward, key_backward, key_left, key_right,
		key_pitch_up, key_pitch_down, key_yaw_left, key_yaw_right, frame_time,
		output ready);
endinterface

interface fcu_res_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic signed [15:0] dir_x;
	logic signed [15:0] dir_y;
	logic signed [15:0] dir_z;
	logic signed [15:0] pitch_deg;
	logic [16:0]        yaw_deg;

	modport source(output valid, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z,
		pitch_deg, yaw_deg, input ready);
	modport sink(input valid, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z,
		pitch_deg, yaw_deg, output ready);
endinterface

interface fcu_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

>>> src/fcu_cordic.sv
module fcu_cordic
	import fcu_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [17:0] ang,
	output logic               done,
	output logic signed [16:0] cos_o,
	output logic signed [16:0] sin_o
);

	logic               busy_q;
	logic               done_q;
	logic               neg_q;
	logic [3:0]         cnt_q;
	logic signed [33:0] x_q;
	logic signed [33:0] y_q;
	logic signed [25:0] z_q;
	logic signed [17:0] ang_f;
	logic               neg_f;
	logic signed [33:0] xs;
	logic signed [33:0] ys;
	logic signed [33:0] xr;
	logic signed [33:0] yr;

	always_comb begin
		ang_f = ang;
		neg_f = 1'b0;
		if (ang > 18'(YAW_QUARTER)) begin
			ang_f = ang - 18'(YAW_HALF);
			neg_f = 1'b1;
		end else if (ang < -18'sd23040) begin
			ang_f = ang + 18'(YAW_HALF);
			neg_f = 1'b1;
		end
	end

	assign xs = x_q >>> cnt_q;
	assign ys = y_q >>> cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= 34'(CORDIC_GAIN);
			y_q   <= '0;
			z_q   <= 26'(ang_f) <<< 8;
			neg_q <= neg_f;
		end else if (busy_q) begin
			if (z_q >= 0) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_q16deg(cnt_q);
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_q16deg(cnt_q);
			end
		end
	end

	assign xr = (x_q + 34'sd32768) >>> 16;
	assign yr = (y_q + 34'sd32768) >>> 16;
	assign cos_o = neg_q ? -xr[16:0] : xr[16:0];
	assign sin_o = neg_q ? -yr[16:0] : yr[16:0];
	assign done  = done_q;

endmodule

>>> src/fcu_sqdiv.sv
module fcu_sqdiv
	import fcu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        div_mode,
	input  logic [31:0] arg,
	input  logic [15:0] den,
	output logic        done,
	output logic [15:0] root,
	output logic [14:0] quot,
	output logic        ovf
);

	logic        busy_q;
	logic        done_q;
	logic        mode_q;
	logic [3:0]  cnt_q;
	logic [31:0] acc_q;
	logic [31:0] r_q;
	logic [31:0] bit_q;
	logic [14:0] q_q;
	logic [15:0] den_q;
	logic        ovf_q;
	logic [31:0] lhs;
	logic [31:0] rhs;
	logic [32:0] diff;
	logic        ge;
	logic        last;

	always_comb begin
		if (mode_q) begin
			lhs = {acc_q[30:0], r_q[14]};
			rhs = 32'(den_q);
		end else begin
			lhs = acc_q;
			rhs = r_q + bit_q;
		end
		diff = {1'b0, lhs} - {1'b0, rhs};
		ge   = !diff[32];
		last = mode_q ? (cnt_q == 4'd14) : (cnt_q == 4'd15);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mode_q <= div_mode;
			den_q  <= den;
			q_q    <= '0;
			bit_q  <= 32'h4000_0000;
			ovf_q  <= arg >= {1'b0, den, 15'b0};
			if (div_mode) begin
				acc_q <= 32'(arg[31:15]);
				r_q   <= 32'(arg[14:0]);
			end else begin
				acc_q <= arg;
				r_q   <= '0;
			end
		end else if (busy_q) begin
			if (mode_q) begin
				acc_q <= ge ? diff[31:0] : lhs;
				q_q   <= {q_q[13:0], ge};
				r_q   <= {r_q[30:0], 1'b0};
			end else begin
				if (ge) begin
					acc_q <= diff[31:0];
					r_q   <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
		end
	end

	assign done = done_q;
	assign root = r_q[15:0];
	assign quot = q_q;
	assign ovf  = ovf_q;

endmodule

>>> src/fcu_core.sv
module fcu_core
	import fcu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg_v,
	input  logic        start,
	input  keys_t       keys,
	input  logic [15:0] frame_time,
	output logic        idle,
	output logic        res_valid,
	input  logic        res_ready,
	output result_t     res_v
);

	typedef enum logic [4:0] {
		S_IDLE, S_SCALE, S_TURN, S_CROSS, S_CROSS_END, S_DV, S_DC, S_DCW, S_APPLY,
		S_ANGLE, S_CP_START, S_CP_WAIT, S_CY_START, S_CY_WAIT, S_F0, S_F2, S_F2W,
		S_SQ, S_SQRT_START, S_SQRT_WAIT, S_DIV_START, S_DIV_WAIT, S_DONE
	} state_t;

	state_t             state_q;
	keys_t              keys_q;
	logic [15:0]        ft_q;
	logic [31:0]        s_q;
	logic [16:0]        turn_q;
	logic [2:0]         cnt_q;
	logic [1:0]         k_q;
	logic signed [33:0] t_q;
	logic signed [21:0] c_q [3];
	logic signed [33:0] dv_q;
	logic signed [33:0] dc_q;
	logic signed [31:0] pos_q [3];
	logic signed [15:0] view_q [3];
	logic signed [15:0] pitch_q;
	logic [16:0]        yaw_q;
	logic signed [16:0] cp_q;
	logic signed [16:0] sp_q;
	logic signed [16:0] cy_q;
	logic signed [16:0] sy_q;
	logic signed [16:0] f_q [3];
	logic [31:0]        acc_q;
	logic [15:0]        len_q;
	logic signed [55:0] prod_s1;

	logic signed [33:0] ma;
	logic signed [21:0] mb;
	logic signed [15:0] up_sel [3];
	logic signed [34:0] step;
	logic               step_en;
	logic signed [34:0] pos_sum;
	logic signed [31:0] pos_sat;
	logic signed [19:0] p_n;
	logic signed [19:0] p_c;
	logic signed [19:0] y_n;
	logic signed [19:0] y_w;
	logic signed [18:0] yw;
	logic               cor_start;
	logic signed [17:0] cor_ang;
	logic               cor_done;
	logic signed [16:0] cor_cos;
	logic signed [16:0] cor_sin;
	logic               sd_start;
	logic               sd_div;
	logic [31:0]        sd_arg;
	logic               sd_done;
	logic [15:0]        sd_root;
	logic [14:0]        sd_quot;
	logic               sd_ovf;
	logic [16:0]        f_mag;
	logic [14:0]        q_clamp;
	logic signed [15:0] dir_new;
	logic               any_turn;

	function automatic logic signed [33:0] rnd_n(input logic signed [55:0] v,
		input logic [4:0] n);
		logic signed [55:0] t;
		t = v + (56'sd1 <<< (n - 5'd1));
		return 34'(t >>> n);
	endfunction

	assign up_sel[0] = cfg_v.up_x;
	assign up_sel[1] = cfg_v.up_y;
	assign up_sel[2] = cfg_v.up_z;
	assign any_turn = keys_q.pitch_up | keys_q.pitch_down | keys_q.yaw_left
		| keys_q.yaw_right;

	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			S_SCALE: begin
				ma = 34'(cfg_v.move_speed);
				mb = 22'(ft_q);
			end
			S_TURN: begin
				ma = 34'(cfg_v.turn_speed);
				mb = 22'(ft_q);
			end
			S_CROSS: begin
				case (cnt_q)
					3'd0: begin ma = 34'(view_q[1]); mb = 22'(up_sel[2]); end
					3'd1: begin ma = 34'(view_q[2]); mb = 22'(up_sel[1]); end
					3'd2: begin ma = 34'(view_q[2]); mb = 22'(up_sel[0]); end
					3'd3: begin ma = 34'(view_q[0]); mb = 22'(up_sel[2]); end
					3'd4: begin ma = 34'(view_q[0]); mb = 22'(up_sel[1]); end
					3'd5: begin ma = 34'(view_q[1]); mb = 22'(up_sel[0]); end
					default: begin ma = '0; mb = '0; end
				endcase
			end
			S_DV: begin
				ma = 34'(s_q);
				mb = 22'(view_q[k_q]);
			end
			S_DC: begin
				ma = 34'(s_q);
				mb = c_q[k_q];
			end
			S_F0: begin
				ma = 34'(cy_q);
				mb = 22'(cp_q);
			end
			S_F2: begin
				ma = 34'(sy_q);
				mb = 22'(cp_q);
			end
			S_SQ: begin
				if (cnt_q < 3'd3) begin
					ma = 34'(f_q[cnt_q[1:0]]);
					mb = 22'(f_q[cnt_q[1:0]]);
				end
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_s1 <= 56'(ma) * 56'(mb);
	end

	always_comb begin
		step    = 35'(dv_q);
		step_en = 1'b0;
		case (cnt_q[1:0])
			2'd0: begin step = 35'(dv_q);  step_en = keys_q.fwd;   end
			2'd1: begin step = -35'(dv_q); step_en = keys_q.bwd;   end
			2'd2: begin step = -35'(dc_q); step_en = keys_q.left;  end
			2'd3: begin step = 35'(dc_q);  step_en = keys_q.right; end
			default: begin step = '0; step_en = 1'b0; end
		endcase
		pos_sum = 35'(pos_q[k_q]) + step;
		if (pos_sum > 35'sd2147483647) begin
			pos_sat = 32'sh7fff_ffff;
		end else if (pos_sum < -35'sd2147483648) begin
			pos_sat = 32'sh8000_0000;
		end else begin
			pos_sat = pos_sum[31:0];
		end
	end

	always_comb begin
		p_n = 20'(pitch_q);
		y_n = signed'(20'(yaw_q));
		if (keys_q.pitch_up)   p_n = p_n + signed'(20'(turn_q));
		if (keys_q.pitch_down) p_n = p_n - signed'(20'(turn_q));
		if (keys_q.yaw_left)   y_n = y_n + signed'(20'(turn_q));
		if (keys_q.yaw_right)  y_n = y_n - signed'(20'(turn_q));
		p_c = p_n;
		if (p_n > 20'(PITCH_LIMIT)) p_c = 20'(PITCH_LIMIT);
		if (p_n < -20'(PITCH_LIMIT)) p_c = -20'(PITCH_LIMIT);
		y_w = y_n;
		if (y_w < 0) y_w = y_w + 20'(YAW_FULL);
		if (y_w < 0) y_w = y_w + 20'(YAW_FULL);
		if (y_w >= 20'(YAW_FULL)) y_w = y_w - 20'(YAW_FULL);
		if (y_w >= 20'(YAW_FULL)) y_w = y_w - 20'(YAW_FULL);
	end

	always_comb begin
		yw = signed'(19'(yaw_q));
		if (yw > 19'(YAW_HALF)) yw = yw - 19'(YAW_FULL);
		cor_start = (state_q == S_CP_START) || (state_q == S_CY_START);
		cor_ang   = (state_q == S_CY_START) ? 18'(yw) : 18'(pitch_q);
		sd_start  = (state_q == S_SQRT_START) || (state_q == S_DIV_START);
		sd_div    = (state_q == S_DIV_START);
		f_mag     = f_q[k_q][16] ? 17'(-f_q[k_q]) : 17'(f_q[k_q]);
		sd_arg    = sd_div ? ({1'b0, f_mag, 14'b0} + 32'(len_q >> 1)) : acc_q;
		q_clamp   = sd_quot;
		if (sd_ovf || sd_quot > 15'(DIR_ONE)) q_clamp = 15'(DIR_ONE);
		dir_new   = f_q[k_q][16] ? -16'(q_clamp) : 16'(q_clamp);
	end

	fcu_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor_start),
		.ang    (cor_ang),
		.done   (cor_done),
		.cos_o  (cor_cos),
		.sin_o  (cor_sin)
	);

	fcu_sqdiv u_sqdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sd_start),
		.div_mode (sd_div),
		.arg      (sd_arg),
		.den      (len_q),
		.done     (sd_done),
		.root     (sd_root),
		.quot     (sd_quot),
		.ovf      (sd_ovf)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			k_q       <= '0;
			pos_q[0]  <= '0;
			pos_q[1]  <= '0;
			pos_q[2]  <= '0;
			view_q[0] <= 16'(DIR_ONE);
			view_q[1] <= '0;
			view_q[2] <= '0;
			pitch_q   <= '0;
			yaw_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) state_q <= S_SCALE;
				end
				S_SCALE: state_q <= S_TURN;
				S_TURN: begin
					cnt_q   <= '0;
					state_q <= S_CROSS;
				end
				S_CROSS: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd5) state_q <= S_CROSS_END;
				end
				S_CROSS_END: begin
					k_q     <= '0;
					state_q <= S_DV;
				end
				S_DV:  state_q <= S_DC;
				S_DC:  state_q <= S_DCW;
				S_DCW: begin
					cnt_q   <= '0;
					state_q <= S_APPLY;
				end
				S_APPLY: begin
					if (step_en) pos_q[k_q] <= pos_sat;
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd3) begin
						if (k_q == 2'd2) begin
							state_q <= any_turn ? S_ANGLE : S_DONE;
						end else begin
							k_q     <= k_q + 2'd1;
							state_q <= S_DV;
						end
					end
				end
				S_ANGLE: begin
					pitch_q <= p_c[15:0];
					yaw_q   <= y_w[16:0];
					state_q <= S_CP_START;
				end
				S_CP_START: state_q <= S_CP_WAIT;
				S_CP_WAIT: begin
					if (cor_done) state_q <= S_CY_START;
				end
				S_CY_START: state_q <= S_CY_WAIT;
				S_CY_WAIT: begin
					if (cor_done) state_q <= S_F0;
				end
				S_F0: state_q <= S_F2;
				S_F2: state_q <= S_F2W;
				S_F2W: begin
					cnt_q   <= '0;
					state_q <= S_SQ;
				end
				S_SQ: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd3) state_q <= S_SQRT_START;
				end
				S_SQRT_START: state_q <= S_SQRT_WAIT;
				S_SQRT_WAIT: begin
					if (sd_done) begin
						k_q     <= '0;
						state_q <= (sd_root == '0) ? S_DONE : S_DIV_START;
					end
				end
				S_DIV_START: state_q <= S_DIV_WAIT;
				S_DIV_WAIT: begin
					if (sd_done) begin
						view_q[k_q] <= dir_new;
						if (k_q == 2'd2) begin
							state_q <= S_DONE;
						end else begin
							k_q     <= k_q + 2'd1;
							state_q <= S_DIV_START;
						end
					end
				end
				S_DONE: begin
					if (res_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				keys_q <= keys;
				ft_q   <= frame_time;
			end
			S_TURN: s_q <= prod_s1[31:0];
			S_CROSS: begin
				case (cnt_q)
					3'd0: begin
						t_q    <= rnd_n(prod_s1, 5'd16);
					end
					3'd1, 3'd3, 3'd5: t_q <= prod_s1[33:0];
					3'd2: c_q[0] <= 22'(rnd_n(56'(t_q) - prod_s1, 5'd14));
					3'd4: c_q[1] <= 22'(rnd_n(56'(t_q) - prod_s1, 5'd14));
					default: t_q <= t_q;
				endcase
				if (cnt_q == 3'd0) turn_q <= 17'(rnd_n(prod_s1, 5'd16));
			end
			S_CROSS_END: c_q[2] <= 22'(rnd_n(56'(t_q) - prod_s1, 5'd14));
			S_DCW: begin
				dc_q <= rnd_n(prod_s1, 5'd22);
			end
			S_DC: dv_q <= rnd_n(prod_s1, 5'd22);
			S_CP_WAIT: begin
				if (cor_done) begin
					cp_q <= cor_cos;
					sp_q <= cor_sin;
				end
			end
			S_CY_WAIT: begin
				if (cor_done) begin
					cy_q <= cor_cos;
					sy_q <= cor_sin;
				end
			end
			S_F2: f_q[0] <= 17'(rnd_n(prod_s1, 5'd14));
			S_F2W: begin
				f_q[1] <= sp_q;
				f_q[2] <= 17'(-rnd_n(prod_s1, 5'd14));
				acc_q  <= '0;
			end
			S_SQ: begin
				if (cnt_q != 3'd0) acc_q <= acc_q + prod_s1[31:0];
			end
			S_SQRT_WAIT: begin
				if (sd_done) len_q <= sd_root;
			end
			default: begin
				ft_q <= ft_q;
			end
		endcase
	end

	assign idle      = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res_v     = '{pos_x: pos_q[0], pos_y: pos_q[1], pos_z: pos_q[2],
		dir_x: view_q[0], dir_y: view_q[1], dir_z: view_q[2],
		pitch_deg: pitch_q, yaw_deg: yaw_q};

	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		pitch_q <= 16'(PITCH_LIMIT) && pitch_q >= -16'(PITCH_LIMIT))
		else $error("pitch out of range");
	a_yaw_range: assert property (@(posedge clk) disable iff (!arst_n)
		yaw_q < 17'(YAW_FULL))
		else $error("yaw not wrapped");
	a_dir_range: assert property (@(posedge clk) disable iff (!arst_n)
		view_q[0] <= 16'(DIR_ONE) && view_q[0] >= -16'(DIR_ONE)
		&& view_q[1] <= 16'(DIR_ONE) && view_q[1] >= -16'(DIR_ONE)
		&& view_q[2] <= 16'(DIR_ONE) && view_q[2] >= -16'(DIR_ONE))
		else $error("view direction out of range");
	a_done_release: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready |=> idle)
		else $error("result taken but sequencer not idle");

endmodule

>>> src/fly_camera_update.sv
// One request at a time. A request without a rotation key runs the shared multiplier
// sequence only; one with a rotation key adds two 16-step CORDIC runs and the
// shift-subtract unit (one root, then three quotients unless the root is zero).
// The finished result waits in an output register while the next request is taken.
// Reset: position zero, view (1,0,0), pitch and yaw zero, registers to defaults.
module fly_camera_update
	import fcu_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	fcu_cmd_if.sink     cmd,
	fcu_res_if.source   res,
	fcu_cfg_if.sink     cfg
);

	cfg_t    cfg_q;
	keys_t   keys;
	logic    core_idle;
	logic    core_valid;
	logic    core_ready;
	result_t core_res;
	result_t res_q;
	logic    res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.move_speed <= 16'd640;
			cfg_q.turn_speed <= 16'd23040;
			cfg_q.up_x       <= '0;
			cfg_q.up_y       <= 16'sd16384;
			cfg_q.up_z       <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_MOVE_SPEED: cfg_q.move_speed <= cfg.data;
				CFG_TURN_SPEED: cfg_q.turn_speed <= cfg.data;
				CFG_UP_X:       cfg_q.up_x       <= cfg.data;
				CFG_UP_Y:       cfg_q.up_y       <= cfg.data;
				CFG_UP_Z:       cfg_q.up_z       <= cfg.data;
				default:        cfg_q            <= cfg_q;
			endcase
		end
	end

	assign cfg.ready = 1'b1;

	assign keys = '{fwd: cmd.key_forward, bwd: cmd.key_backward, left: cmd.key_left,
		right: cmd.key_right, pitch_up: cmd.key_pitch_up,
		pitch_down: cmd.key_pitch_down, yaw_left: cmd.key_yaw_left,
		yaw_right: cmd.key_yaw_right};

	assign cmd.ready  = core_idle;
	assign core_ready = !res_valid_q || res.ready;

	fcu_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_v      (cfg_q),
		.start      (cmd.valid),
		.keys       (keys),
		.frame_time (cmd.frame_time),
		.idle       (core_idle),
		.res_valid  (core_valid),
		.res_ready  (core_ready),
		.res_v      (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (core_valid && core_ready) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (core_valid && core_ready) res_q <= core_res;
	end

	assign res.valid     = res_valid_q;
	assign res.pos_x     = res_q.pos_x;
	assign res.pos_y     = res_q.pos_y;
	assign res.pos_z     = res_q.pos_z;
	assign res.dir_x     = res_q.dir_x;
	assign res.dir_y     = res_q.dir_y;
	assign res.dir_z     = res_q.dir_z;
	assign res.pitch_deg = res_q.pitch_deg;
	assign res.yaw_deg   = res_q.yaw_deg;

endmodule
